/* rtl/core/shared_exclusive_lock_table_macros.svh */
// Assertion macros shared by the lock table modules.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef SHARED_EXCLUSIVE_LOCK_TABLE_MACROS_SVH
`define SHARED_EXCLUSIVE_LOCK_TABLE_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define SEL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define SEL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/sel_pkg.sv */
// Package of the shared/exclusive lock table: sizes, status codes,
// controller opcodes and the datapath status struct. No dependencies.
`default_nettype none

package sel_pkg;

  localparam int NUM_TXNS      = 16;
  localparam int NUM_RESOURCES = 64;
  localparam int TXN_W         = 4;
  localparam int RES_W         = 6;
  localparam int STATUS_W      = 3;
  localparam int NIDX_W        = $clog2(NUM_TXNS);
  localparam int NODE_W        = $clog2(NUM_TXNS + 1);
  localparam int RIDX_W        = $clog2(NUM_RESOURCES);
  localparam int SWEEP_W       = $clog2(NUM_RESOURCES + 1);

  typedef logic [NUM_TXNS-1:0] txn_mask_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED  = 3'd0,
    ST_WAITING  = 3'd1,
    ST_ABORT    = 3'd2,
    ST_HELD     = 3'd3,
    ST_RELEASED = 3'd4,
    ST_REJECTED = 3'd5
  } status_e;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ,
    OP_DECIDE,
    OP_REACH,
    OP_NODE_SEL,
    OP_NODE_EXP,
    OP_SWEEP,
    OP_CAND,
    OP_NEXTW,
    OP_EMIT
  } op_e;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic decided;
    logic reach_stable;
    logic node_done;
    logic node_skip;
    logic cyc_found;
    logic exp_stable;
    logic sweep_done;
    logic more_waiters;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/core/sel_if.sv */
// Valid/ready channel interfaces of the lock table: request and result.
// Depends on sel_pkg for field widths.
`default_nettype none

interface sel_req_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [sel_pkg::TXN_W-1:0]   txn;
  logic [sel_pkg::RES_W-1:0]   resource;
  logic                        exclusive;

  modport source (output valid, cmd, txn, resource, exclusive, input ready);
  modport sink (input valid, cmd, txn, resource, exclusive, output ready);
endinterface

interface sel_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sel_pkg::TXN_W-1:0]    who;
  logic [sel_pkg::STATUS_W-1:0] status;
  logic                         last;

  modport source (output valid, who, status, last, input ready);
  modport sink (input valid, who, status, last, output ready);
endinterface

`default_nettype wire

/* rtl/core/sel_datapath.sv */
// Datapath of the lock table: lock memory, waits-for matrix, pending
// requests, reachability search and result register. Uses sel_pkg.
`default_nettype none

`include "shared_exclusive_lock_table_macros.svh"

module sel_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire sel_pkg::op_e                 op_i,
  output sel_pkg::dp_stat_t                 stat_o,
  input  wire logic                         req_cmd_i,
  input  wire logic [sel_pkg::TXN_W-1:0]    req_txn_i,
  input  wire logic [sel_pkg::RES_W-1:0]    req_resource_i,
  input  wire logic                         req_exclusive_i,
  output logic                              rsp_valid_o,
  input  wire logic                         rsp_ready_i,
  output logic [sel_pkg::TXN_W-1:0]         rsp_who_o,
  output logic [sel_pkg::STATUS_W-1:0]      rsp_status_o,
  output logic                              rsp_last_o
);

  localparam int N = sel_pkg::NUM_TXNS;

  typedef logic [N-1:0][N-1:0] wf_mat_t;

  // One reachability step: add every successor of the set.
  function automatic sel_pkg::txn_mask_t expand1(sel_pkg::txn_mask_t s, wf_mat_t rows);
    sel_pkg::txn_mask_t acc;
    acc = s;
    for (int i = 0; i < N; i++) begin
      if (s[i]) acc = acc | rows[i];
    end
    return acc;
  endfunction

  // Lock memory: each row holds {exclusive holders, holders}.
  logic [2*N-1:0]               mem [sel_pkg::NUM_RESOURCES];
  logic [sel_pkg::NUM_RESOURCES-1:0] row_vld_q;
  logic [2*N-1:0]               rd_q;
  logic                         rd_vld_q;

  logic                         mem_we;
  logic [sel_pkg::RIDX_W-1:0]   mem_wa;
  logic [2*N-1:0]               mem_wd;
  logic                         mem_re;
  logic [sel_pkg::RIDX_W-1:0]   mem_ra;

  // Current request and search state.
  logic [sel_pkg::NIDX_W-1:0]   cur_t_q;
  logic [sel_pkg::RES_W-1:0]    cur_r_q;
  logic                         cur_ex_q;
  logic                         acq_q;
  wf_mat_t                      wf_q;
  sel_pkg::txn_mask_t           waiting_q;
  logic [sel_pkg::RES_W-1:0]    wres_q [N];
  logic                         wex_q [N];
  sel_pkg::txn_mask_t           reach_q;
  sel_pkg::txn_mask_t           nset_q;
  logic [sel_pkg::NODE_W-1:0]   node_q;
  logic [sel_pkg::SWEEP_W-1:0]  sweep_q;
  sel_pkg::txn_mask_t           cand_q;
  sel_pkg::status_e             res_status_q;
  logic                         res_last_q;
  logic                         out_vld_q;
  logic [sel_pkg::NIDX_W-1:0]   out_who_q;
  sel_pkg::status_e             out_status_q;
  logic                         out_last_q;

  sel_pkg::txn_mask_t           rd_gm;
  sel_pkg::txn_mask_t           rd_em;
  sel_pkg::txn_mask_t           self_bit;
  sel_pkg::txn_mask_t           others;
  sel_pkg::txn_mask_t           conflict;
  sel_pkg::txn_mask_t           reach_nx;
  sel_pkg::txn_mask_t           nset_nx;
  logic [sel_pkg::NIDX_W-1:0]   node_idx;
  logic [sel_pkg::RIDX_W-1:0]   sweep_wa;
  logic                         acq_reject;
  logic                         acq_held;
  logic [sel_pkg::NIDX_W-1:0]   pick;
  logic                         out_free;

  // Decode of the row read in the previous cycle.
  assign rd_gm    = rd_vld_q ? rd_q[N-1:0] : '0;
  assign rd_em    = rd_vld_q ? rd_q[2*N-1:N] : '0;
  assign self_bit = sel_pkg::txn_mask_t'(1) << cur_t_q;
  assign others   = rd_gm & ~self_bit;
  assign conflict = cur_ex_q ? others : (others & rd_em);
  assign acq_reject = acq_q && waiting_q[cur_t_q];
  assign acq_held   = acq_q && rd_gm[cur_t_q];
  assign reach_nx = expand1(reach_q, wf_q);
  assign nset_nx  = expand1(nset_q, wf_q);
  assign node_idx = node_q[sel_pkg::NIDX_W-1:0];
  assign sweep_wa = sel_pkg::RIDX_W'(sweep_q - 1'b1);
  assign out_free = !out_vld_q || rsp_ready_i;

  // Lowest pending waiter to re-check next.
  always_comb begin
    pick = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (cand_q[i]) pick = sel_pkg::NIDX_W'(i);
    end
  end

  // Status toward the controller.
  always_comb begin
    stat_o.decided      = acq_reject || acq_held || (conflict == '0);
    stat_o.reach_stable = (reach_nx == reach_q);
    stat_o.node_done    = (node_q == sel_pkg::NODE_W'(N));
    stat_o.node_skip    = !reach_q[node_idx];
    stat_o.cyc_found    = nset_nx[node_idx];
    stat_o.exp_stable   = (nset_nx == nset_q);
    stat_o.sweep_done   = (sweep_q == sel_pkg::SWEEP_W'(sel_pkg::NUM_RESOURCES));
    stat_o.more_waiters = !res_last_q;
    stat_o.out_free     = out_free;
  end

  // Memory port control.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur_r_q;
    mem_wd = {rd_em | (cur_ex_q ? self_bit : '0), rd_gm | self_bit};
    mem_re = 1'b0;
    mem_ra = cur_r_q;
    case (op_i)
      sel_pkg::OP_READ: begin
        mem_re = 1'b1;
      end
      sel_pkg::OP_DECIDE: begin
        mem_we = !acq_reject && !acq_held && (conflict == '0);
      end
      sel_pkg::OP_SWEEP: begin
        mem_re = !stat_o.sweep_done;
        mem_ra = sweep_q[sel_pkg::RIDX_W-1:0];
        mem_we = (sweep_q != '0);
        mem_wa = sweep_wa;
        mem_wd = {rd_em & ~self_bit, rd_gm & ~self_bit};
      end
      default: begin
      end
    endcase
  end

  // Lock memory with registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem[mem_ra];
  end

  // Pending request details, written when a transaction starts waiting.
  always_ff @(posedge clk_i) begin
    if (op_i == sel_pkg::OP_NODE_SEL && stat_o.node_done) begin
      wres_q[cur_t_q] <= cur_r_q;
      wex_q[cur_t_q]  <= cur_ex_q;
    end
  end

  // Control state and table bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q    <= '0;
      rd_vld_q     <= 1'b0;
      cur_t_q      <= '0;
      cur_r_q      <= '0;
      cur_ex_q     <= 1'b0;
      acq_q        <= 1'b0;
      wf_q         <= '0;
      waiting_q    <= '0;
      reach_q      <= '0;
      nset_q       <= '0;
      node_q       <= '0;
      sweep_q      <= '0;
      cand_q       <= '0;
      res_status_q <= sel_pkg::ST_GRANTED;
      res_last_q   <= 1'b1;
      out_vld_q    <= 1'b0;
      out_who_q    <= '0;
      out_status_q <= sel_pkg::ST_GRANTED;
      out_last_q   <= 1'b0;
    end else begin
      if (mem_we) row_vld_q[mem_wa] <= 1'b1;
      if (mem_re) rd_vld_q <= row_vld_q[mem_ra];
      if (out_vld_q && rsp_ready_i && (op_i != sel_pkg::OP_EMIT)) out_vld_q <= 1'b0;

      case (op_i)
        sel_pkg::OP_LOAD: begin
          cur_t_q  <= req_txn_i;
          cur_r_q  <= req_resource_i;
          cur_ex_q <= req_exclusive_i;
          acq_q    <= !req_cmd_i;
          sweep_q  <= '0;
          cand_q   <= '0;
        end
        sel_pkg::OP_DECIDE: begin
          res_last_q <= (cand_q == '0);
          if (acq_reject) begin
            res_status_q <= sel_pkg::ST_REJECTED;
          end else if (acq_held) begin
            res_status_q <= sel_pkg::ST_HELD;
          end else if (conflict == '0) begin
            res_status_q       <= sel_pkg::ST_GRANTED;
            wf_q[cur_t_q]      <= '0;
            waiting_q[cur_t_q] <= 1'b0;
          end else begin
            wf_q[cur_t_q] <= wf_q[cur_t_q] | conflict;
            reach_q       <= self_bit;
          end
        end
        sel_pkg::OP_REACH: begin
          reach_q <= reach_nx;
          node_q  <= '0;
        end
        sel_pkg::OP_NODE_SEL: begin
          if (stat_o.node_done) begin
            res_status_q       <= sel_pkg::ST_WAITING;
            waiting_q[cur_t_q] <= 1'b1;
          end else if (stat_o.node_skip) begin
            node_q <= node_q + 1'b1;
          end else begin
            nset_q <= wf_q[node_idx];
          end
        end
        sel_pkg::OP_NODE_EXP: begin
          nset_q <= nset_nx;
          if (stat_o.cyc_found) begin
            res_status_q       <= sel_pkg::ST_ABORT;
            wf_q[cur_t_q]      <= '0;
            waiting_q[cur_t_q] <= 1'b0;
          end else if (stat_o.exp_stable) begin
            node_q <= node_q + 1'b1;
          end
        end
        sel_pkg::OP_SWEEP: begin
          if (!stat_o.sweep_done) sweep_q <= sweep_q + 1'b1;
          // A waiter whose resource the releasing transaction held is queued.
          if (sweep_q != '0 && rd_gm[cur_t_q]) begin
            for (int w = 0; w < N; w++) begin
              if (waiting_q[w] && (sel_pkg::NIDX_W'(w) != cur_t_q) &&
                  (wres_q[w] == sel_pkg::RES_W'(sweep_wa))) begin
                cand_q[w] <= 1'b1;
              end
            end
          end
        end
        sel_pkg::OP_CAND: begin
          waiting_q[cur_t_q] <= 1'b0;
          for (int i = 0; i < N; i++) begin
            if (sel_pkg::NIDX_W'(i) != cur_t_q) wf_q[i][cur_t_q] <= 1'b0;
          end
          wf_q[cur_t_q] <= '0;
          res_status_q  <= sel_pkg::ST_RELEASED;
          res_last_q    <= (cand_q == '0);
        end
        sel_pkg::OP_NEXTW: begin
          cur_t_q      <= pick;
          cur_r_q      <= wres_q[pick];
          cur_ex_q     <= wex_q[pick];
          cand_q[pick] <= 1'b0;
        end
        sel_pkg::OP_EMIT: begin
          out_vld_q    <= 1'b1;
          out_who_q    <= cur_t_q;
          out_status_q <= res_status_q;
          out_last_q   <= res_last_q;
        end
        default: begin
        end
      endcase
    end
  end

  assign rsp_valid_o  = out_vld_q;
  assign rsp_who_o    = sel_pkg::TXN_W'(out_who_q);
  assign rsp_status_o = out_status_q;
  assign rsp_last_o   = out_last_q;

  `SEL_ASSERT(a_sweep_bound, sweep_q <= sel_pkg::SWEEP_W'(sel_pkg::NUM_RESOURCES), "sweep counter overran the table")
  `SEL_ASSERT(a_excl_subset, !rd_vld_q || ((rd_em & ~rd_gm) == '0), "exclusive holder missing from holders")
  `SEL_ASSERT(a_emit_free, (op_i != sel_pkg::OP_EMIT) || out_free, "result word loaded over a pending one")

endmodule

`default_nettype wire

/* rtl/core/sel_ctrl.sv */
// Controller of the lock table: sequences acquire, deadlock search,
// release sweep and waiter re-checks. Uses sel_pkg.
`default_nettype none

`include "shared_exclusive_lock_table_macros.svh"

module sel_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  input  wire logic              req_cmd_i,
  output logic                   req_ready_o,
  output sel_pkg::op_e           op_o,
  input  wire sel_pkg::dp_stat_t stat_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_DECIDE,
    S_REACH,
    S_NODE_SEL,
    S_NODE_EXP,
    S_SWEEP,
    S_CAND,
    S_NEXTW,
    S_EMIT
  } state_e;

  state_e state_q;
  state_e state_d;

  assign req_ready_o = (state_q == S_IDLE);

  // Next state and datapath command.
  always_comb begin
    state_d = state_q;
    op_o    = sel_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_o    = sel_pkg::OP_LOAD;
          state_d = req_cmd_i ? S_SWEEP : S_READ;
        end
      end
      S_READ: begin
        op_o    = sel_pkg::OP_READ;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        op_o    = sel_pkg::OP_DECIDE;
        state_d = stat_i.decided ? S_EMIT : S_REACH;
      end
      S_REACH: begin
        op_o = sel_pkg::OP_REACH;
        if (stat_i.reach_stable) state_d = S_NODE_SEL;
      end
      S_NODE_SEL: begin
        op_o = sel_pkg::OP_NODE_SEL;
        if (stat_i.node_done) begin
          state_d = S_EMIT;
        end else if (!stat_i.node_skip) begin
          state_d = S_NODE_EXP;
        end
      end
      S_NODE_EXP: begin
        op_o = sel_pkg::OP_NODE_EXP;
        if (stat_i.cyc_found) begin
          state_d = S_EMIT;
        end else if (stat_i.exp_stable) begin
          state_d = S_NODE_SEL;
        end
      end
      S_SWEEP: begin
        op_o = sel_pkg::OP_SWEEP;
        if (stat_i.sweep_done) state_d = S_CAND;
      end
      S_CAND: begin
        op_o    = sel_pkg::OP_CAND;
        state_d = S_EMIT;
      end
      S_NEXTW: begin
        op_o    = sel_pkg::OP_NEXTW;
        state_d = S_READ;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          op_o    = sel_pkg::OP_EMIT;
          state_d = stat_i.more_waiters ? S_NEXTW : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `SEL_ASSERT_NEXT(a_busy_after_load, req_valid_i && req_ready_o, !req_ready_o, "took a word while busy")
  `SEL_ASSERT(a_emit_only_in_emit, (op_o != sel_pkg::OP_EMIT) || stat_i.out_free, "emit without room")
  `SEL_ASSERT_NEXT(a_cand_to_emit, state_q == S_CAND, state_q == S_EMIT, "release word not queued")

endmodule

`default_nettype wire

/* rtl/core/shared_exclusive_lock_table.sv */
// Acquire: once a request is taken, its lock row is read and decided and the result
// word loaded; on a conflict the reachability search and a per-node check come first.
// Release: a sweep of the 64 rows precedes the released word, then each woken waiter
// is read and decided again, with any search, before its own word.
// A stalled result holds the controller; the next request is taken the cycle after the
// last word is loaded. Reset is asynchronous; row valid bits make the table read empty.
`default_nettype none

module shared_exclusive_lock_table (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sel_req_if.sink   req_i,
  sel_rsp_if.source rsp_o
);

  sel_pkg::op_e      op;
  sel_pkg::dp_stat_t stat;
  logic              ready;

  assign req_i.ready = ready;

  sel_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_cmd_i   (req_i.cmd),
    .req_ready_o (ready),
    .op_o        (op),
    .stat_i      (stat)
  );

  sel_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .stat_o          (stat),
    .req_cmd_i       (req_i.cmd),
    .req_txn_i       (req_i.txn),
    .req_resource_i  (req_i.resource),
    .req_exclusive_i (req_i.exclusive),
    .rsp_valid_o     (rsp_o.valid),
    .rsp_ready_i     (rsp_o.ready),
    .rsp_who_o       (rsp_o.who),
    .rsp_status_o    (rsp_o.status),
    .rsp_last_o      (rsp_o.last)
  );

endmodule

`default_nettype wire

/* tb/sel_lock_checker.sv */
// Checker of the lock table: watches the request and result channels,
// predicts every result word and compares it. Depends on sel_pkg and sel_if.
`timescale 1ns / 1ps

module sel_lock_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sel_req_if        req_i,
  sel_rsp_if        rsp_i,
  output int        errors_o,
  output int        pending_o,
  output int        results_o
);

  typedef struct packed {
    logic [sel_pkg::TXN_W-1:0] who;
    sel_pkg::status_e          status;
    logic                      last;
  } lock_result_t;

  // Model copy of the lock table.
  sel_pkg::txn_mask_t        holders [sel_pkg::NUM_RESOURCES];
  sel_pkg::txn_mask_t        ex_holders [sel_pkg::NUM_RESOURCES];
  logic                      blocked [sel_pkg::NUM_TXNS];
  logic [sel_pkg::RES_W-1:0] blocked_res [sel_pkg::NUM_TXNS];
  logic                      blocked_ex [sel_pkg::NUM_TXNS];
  sel_pkg::txn_mask_t        waits_on [sel_pkg::NUM_TXNS];

  lock_result_t     expected_q[$];

  // All transactions reachable from a set through waits-for edges.
  function automatic sel_pkg::txn_mask_t reach_from(sel_pkg::txn_mask_t seed);
    sel_pkg::txn_mask_t prev;
    do begin
      prev = seed;
      for (int i = 0; i < sel_pkg::NUM_TXNS; i++) begin
        if (seed[i]) seed |= waits_on[i];
      end
    end while (seed != prev);
    return seed;
  endfunction

  function automatic logic cycle_seen(int t);
    sel_pkg::txn_mask_t reach;
    sel_pkg::txn_mask_t back;
    reach = reach_from(sel_pkg::txn_mask_t'(1) << t);
    for (int n = 0; n < sel_pkg::NUM_TXNS; n++) begin
      back = reach_from(waits_on[n]);
      if (reach[n] && back[n]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // One lock attempt of transaction t on resource r.
  function automatic sel_pkg::status_e try_lock(int t, int r, logic ex);
    sel_pkg::txn_mask_t others, conflict;
    others   = holders[r] & ~(sel_pkg::txn_mask_t'(1) << t);
    conflict = ex ? others : (others & ex_holders[r]);
    if (conflict == '0) begin
      holders[r][t] = 1'b1;
      if (ex) ex_holders[r][t] = 1'b1;
      waits_on[t] = '0;
      blocked[t]  = 1'b0;
      return sel_pkg::ST_GRANTED;
    end
    waits_on[t] |= conflict;
    if (cycle_seen(t)) begin
      waits_on[t] = '0;
      blocked[t]  = 1'b0;
      return sel_pkg::ST_ABORT;
    end
    blocked[t]     = 1'b1;
    blocked_res[t] = sel_pkg::RES_W'(r);
    blocked_ex[t]  = ex;
    return sel_pkg::ST_WAITING;
  endfunction

  task automatic push_result(int who, sel_pkg::status_e st);
    lock_result_t res;
    res.who    = sel_pkg::TXN_W'(who);
    res.status = st;
    res.last   = 1'b0;
    expected_q.insert(expected_q.size(), res);
  endtask

  // Predicts all result words caused by one request word.
  task automatic predict_request(logic cmd, int t, int r, logic ex);
    logic freed [sel_pkg::NUM_RESOURCES];
    int   first;
    first = expected_q.size();
    if (cmd == 1'b0) begin
      if (blocked[t]) push_result(t, sel_pkg::ST_REJECTED);
      else if (holders[r][t]) push_result(t, sel_pkg::ST_HELD);
      else push_result(t, try_lock(t, r, ex));
    end else begin
      for (int i = 0; i < sel_pkg::NUM_RESOURCES; i++) begin
        freed[i]         = holders[i][t];
        holders[i][t]    = 1'b0;
        ex_holders[i][t] = 1'b0;
      end
      blocked[t]  = 1'b0;
      waits_on[t] = '0;
      for (int i = 0; i < sel_pkg::NUM_TXNS; i++) waits_on[i][t] = 1'b0;
      push_result(t, sel_pkg::ST_RELEASED);
      for (int w = 0; w < sel_pkg::NUM_TXNS; w++) begin
        if (blocked[w] && freed[blocked_res[w]]) begin
          push_result(w, try_lock(w, int'(blocked_res[w]), blocked_ex[w]));
        end
      end
    end
    expected_q[expected_q.size()-1].last = 1'b1;
    if (first >= expected_q.size()) errors_o++;
  endtask

  task automatic report(string what, int got, int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o  = 0;
    results_o = 0;
    pending_o = 0;
    for (int i = 0; i < sel_pkg::NUM_RESOURCES; i++) begin
      holders[i]    = '0;
      ex_holders[i] = '0;
    end
    for (int i = 0; i < sel_pkg::NUM_TXNS; i++) begin
      blocked[i]     = 1'b0;
      blocked_res[i] = '0;
      blocked_ex[i]  = 1'b0;
      waits_on[i]    = '0;
    end
  end

  // Handshakes are sampled at the rising edge with the values of the cycle before.
  always @(posedge clk_i) begin
    lock_result_t want;
    if (rst_ni) begin
      if (req_i.valid && req_i.ready) begin
        predict_request(req_i.cmd, int'(req_i.txn), int'(req_i.resource), req_i.exclusive);
      end
      if (rsp_i.valid && rsp_i.ready) begin
        results_o++;
        if (expected_q.size() == 0) begin
          report("unexpected word, who", int'(rsp_i.who), 0);
        end else begin
          want = expected_q.pop_front();
          if (rsp_i.who !== want.who) report("who", int'(rsp_i.who), int'(want.who));
          if (rsp_i.status !== want.status) begin
            report("status", int'(rsp_i.status), int'(want.status));
          end
          if (rsp_i.last !== want.last) report("last", int'(rsp_i.last), int'(want.last));
        end
      end
    end
    pending_o = expected_q.size();
  end
endmodule

/* tb/testbench.sv */
// Top of the lock table testbench: clock, reset, request stimulus and
// result back-pressure. Depends on sel_pkg, sel_if and sel_lock_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic clk_i;
  logic rst_ni;
  logic calm;
  int   cycles;
  int   errors;
  int   pending;
  int   results;
  int   sent;

  sel_req_if req_ch ();
  sel_rsp_if rsp_ch ();

  shared_exclusive_lock_table u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  sel_lock_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_ch),
    .rsp_i     (rsp_ch),
    .errors_o  (errors),
    .pending_o (pending),
    .results_o (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench failed");
      $finish;
    end
  end

  // Result side stalls with a probability of 29 percent, except in calm stretches.
  always @(posedge clk_i) begin
    if (!rst_ni) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= calm || ($urandom_range(99) >= 29);
  end

  // Sends one request word, with a random gap before it.
  task automatic send_word(logic cmd, int t, int r, logic ex);
    while (!calm && $urandom_range(99) < 29) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.cmd       <= cmd;
    req_ch.txn       <= sel_pkg::TXN_W'(t);
    req_ch.resource  <= sel_pkg::RES_W'(r);
    req_ch.exclusive <= ex;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic acquire(int t, int r, logic ex);
    send_word(1'b0, t, r, ex);
  endtask

  task automatic release_txn(int t);
    send_word(1'b1, t, int'($urandom_range(63)), 1'($urandom_range(1)));
  endtask

  initial begin
    int drain;
    cycles           = 0;
    sent             = 0;
    calm             = 1'b0;
    rst_ni           = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.cmd       = 1'b0;
    req_ch.txn       = '0;
    req_ch.resource  = '0;
    req_ch.exclusive = 1'b0;
    rsp_ch.ready     = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: shared sharing, held, waiting, rejected while waiting,
    // deadlock victim, wake-ups on release and release while waiting.
    acquire(0, 0, 1'b0);
    acquire(1, 0, 1'b0);
    acquire(0, 0, 1'b1);
    acquire(2, 0, 1'b1);
    acquire(2, 5, 1'b0);
    acquire(3, 63, 1'b1);
    acquire(0, 63, 1'b0);
    acquire(15, 1, 1'b1);
    acquire(3, 1, 1'b1);
    acquire(15, 63, 1'b1);
    release_txn(1);
    release_txn(3);
    release_txn(0);
    acquire(4, 42, 1'b0);
    acquire(5, 42, 1'b0);
    acquire(6, 42, 1'b1);
    acquire(7, 42, 1'b1);
    release_txn(4);
    release_txn(5);
    release_txn(7);
    release_txn(8);
    release_txn(2);
    release_txn(6);
    release_txn(15);

    // Random: a small pool of resources keeps conflicts and deadlocks common.
    for (int i = 0; i < 330; i++) begin
      calm = (i >= 150 && i < 220);
      if ($urandom_range(99) < 25) release_txn(int'($urandom_range(15)));
      else if ($urandom_range(9) == 0)
        acquire(int'($urandom_range(15)), int'($urandom_range(63)), 1'($urandom_range(1)));
      else acquire(int'($urandom_range(15)), int'($urandom_range(7)), 1'($urandom_range(1)));
    end
    calm = 1'b0;
    req_ch.valid <= 1'b0;

    // Drain, then allow for the longest search before the verdict.
    while (pending != 0) @(posedge clk_i);
    drain = 0;
    while (drain < 2000) begin
      @(posedge clk_i);
      drain++;
    end

    $display("sent %0d request words, checked %0d result words, %0d mismatches",
             sent, results, errors);
    $display("covered grants, waits, deadlock aborts, wake-ups and rejects");
    if (errors == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
